FILE: rtl/smid_pkg.sv
// ----------------------------------------------------------------------------
// smid_pkg: shared types and constants of the sorted multiset block
// Capacity, field widths, status codes and the structs passed between cells.
// ----------------------------------------------------------------------------
`default_nettype none

package smid_pkg;

  localparam int unsigned Capacity = 16;
  localparam int unsigned CntW     = $clog2(Capacity + 1);
  localparam int unsigned ValW     = 32;
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 72;

  typedef enum logic [2:0] {
    StInserted = 3'd0,
    StDeleted  = 3'd1,
    StNotFound = 3'd2,
    StEmpty    = 3'd3,
    StFull     = 3'd4
  } status_e;

  // Broadcast operation seen by every cell.
  typedef struct packed {
    logic                   ins_en;  // commit an insert this cycle
    logic                   del_en;  // commit a delete this cycle
    logic signed [ValW-1:0] value;
  } op_t;

  // What a cell shows to its neighbours.
  typedef struct packed {
    logic                   valid;
    logic                   gt;      // valid and held value > operand
    logic signed [ValW-1:0] value;
  } link_t;

endpackage

`default_nettype wire

FILE: rtl/smid_cell.sv
// ----------------------------------------------------------------------------
// smid_cell: one slot of the sorted chain
// Holds one value and its valid bit; shifts right on insert, left on delete.
// ----------------------------------------------------------------------------
`default_nettype none

module smid_cell (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire smid_pkg::op_t   op_i,
  input  wire smid_pkg::link_t left_i,   // neighbour at the lower index
  input  wire smid_pkg::link_t right_i,  // neighbour at the higher index
  input  wire logic           seen_i,    // a match lies at a lower index
  output logic                seen_o,
  output smid_pkg::link_t      self_o,
  output logic                valid_d_o,
  output logic signed [smid_pkg::ValW-1:0] value_d_o
);

  logic                              valid_q, valid_d;
  logic signed [smid_pkg::ValW-1:0]  value_q, value_d;
  logic                              le, match;

  assign le     = valid_q && (value_q <= op_i.value);
  assign match  = valid_q && (value_q == op_i.value);
  assign seen_o = seen_i | match;

  assign self_o.valid = valid_q;
  assign self_o.gt    = valid_q && (value_q > op_i.value);
  assign self_o.value = value_q;

  always_comb begin
    valid_d = valid_q;
    value_d = value_q;
    if (op_i.ins_en) begin
      valid_d = left_i.valid;
      if (!le) begin
        // take the neighbour's value while it is still above the operand
        value_d = left_i.gt ? left_i.value : op_i.value;
      end
    end else if (op_i.del_en) begin
      valid_d = right_i.valid;
      if (seen_o) begin
        value_d = right_i.value;
      end
    end
  end

  assign valid_d_o = valid_d;
  assign value_d_o = value_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

endmodule

`default_nettype wire

FILE: rtl/sorted_multiset_insert_delete.sv
// ----------------------------------------------------------------------------
// sorted_multiset_insert_delete: bounded sorted multiset of signed values
// A chain of cells keeps the values in ascending order, one per cell.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel s_axis_*: one transfer per operation. tdata[0] is func
//   (0 insert, 1 delete one equal entry), tdata[32:1] the signed value.
//   Master channel m_axis_*: one transfer per operation with the status,
//   the count held afterwards and the smallest and largest held values
//   (both 0 when the list is empty).
//   Every cell compares the broadcast operand with its own value and with
//   its neighbours' in the same cycle, so the result is registered and
//   shown in the cycle after the input transfer, and one operation per
//   cycle is sustained while the receiver does not stall. The delete search
//   ripples a match flag along the chain, which sets the critical path.
//   An insert into a full list reports full, a delete from an empty list
//   reports empty, a delete without a match reports not found; none of
//   them alters the list. Duplicates are kept.
//   Reset clears every valid bit and the count; the list starts empty and
//   no result is pending. While the receiver stalls, the result register
//   holds and s_axis_tready drops; it rises again when the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_multiset_insert_delete (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // func[0], value[32:1], zero pad
  input  wire logic [smid_pkg::InDataW-1:0]    s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // status[2:0], count[7:3], min_value[39:8], max_value[71:40]
  output logic [smid_pkg::OutDataW-1:0]        m_axis_tdata
);

  localparam int unsigned N = smid_pkg::Capacity;

  logic                              accept;
  logic                              func;
  logic signed [smid_pkg::ValW-1:0]  value;
  smid_pkg::op_t                     op;
  smid_pkg::link_t                   links [N];
  logic [N:0]                        seen;
  logic [N-1:0]                      valid_d;
  logic signed [smid_pkg::ValW-1:0]  value_d [N];
  logic [smid_pkg::CntW-1:0]         count_q, count_d;
  logic                              full, empty, found;
  smid_pkg::status_e                 status;
  logic [smid_pkg::ValW-1:0]         max_mux;
  logic [smid_pkg::CntW+4:0]         count_ext;

  logic                              out_valid_q;
  smid_pkg::status_e                 status_q;
  logic [4:0]                        count_out_q;
  logic signed [smid_pkg::ValW-1:0]  min_q, max_q;

  // Accept while the result register is empty or being drained.
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign func          = s_axis_tdata[0];
  assign value         = s_axis_tdata[smid_pkg::ValW:1];

  assign full  = (count_q == smid_pkg::CntW'(N));
  assign empty = (count_q == '0);
  assign found = seen[N];

  assign op.ins_en = accept && !func && !full;
  assign op.del_en = accept && func && found;
  assign op.value  = value;

  assign seen[0] = 1'b0;

  for (genvar i = 0; i < N; i++) begin : g_cell
    smid_pkg::link_t left, right;
    if (i == 0) begin : g_head
      // the head always becomes valid on insert and never shifts a value in
      assign left = '{valid: 1'b1, gt: 1'b0, value: '0};
    end else begin : g_mid
      assign left = links[i-1];
    end
    if (i == N - 1) begin : g_tail
      assign right = '{valid: 1'b0, gt: 1'b0, value: '0};
    end else begin : g_body
      assign right = links[i+1];
    end

    smid_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .op_i      (op),
      .left_i    (left),
      .right_i   (right),
      .seen_i    (seen[i]),
      .seen_o    (seen[i+1]),
      .self_o    (links[i]),
      .valid_d_o (valid_d[i]),
      .value_d_o (value_d[i])
    );
  end

  always_comb begin
    count_d = count_q;
    if (op.ins_en) begin
      count_d = count_q + 1'b1;
    end else if (op.del_en) begin
      count_d = count_q - 1'b1;
    end
  end

  always_comb begin
    if (!func) begin
      status = full ? smid_pkg::StFull : smid_pkg::StInserted;
    end else if (empty) begin
      status = smid_pkg::StEmpty;
    end else if (!found) begin
      status = smid_pkg::StNotFound;
    end else begin
      status = smid_pkg::StDeleted;
    end
  end

  // Select the tail cell of the next state: valid with no valid successor.
  always_comb begin
    max_mux = '0;
    for (int unsigned i = 0; i < N; i++) begin
      if (valid_d[i] && ((i == N - 1) || !valid_d[(i + 1) % N])) begin
        max_mux = max_mux | value_d[i];
      end
    end
  end

  assign count_ext = {5'b0, count_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload: load on every accepted transfer, hold otherwise.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q    <= status;
      count_out_q <= count_ext[4:0];
      min_q       <= valid_d[0] ? value_d[0] : '0;
      max_q       <= max_mux;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {max_q, min_q, count_out_q, status_q};

`ifndef NO_ASSERTIONS
  logic [N-1:0] valid_now;
  for (genvar i = 0; i < N; i++) begin : g_vld
    assign valid_now[i] = links[i].valid;
  end

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= smid_pkg::CntW'(N))
    else $error("count exceeds capacity");

  a_valid_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_now) == int'(count_q))
    else $error("valid bits disagree with count");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (status_q == smid_pkg::StFull)) |-> full)
    else $error("full reported below capacity");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (count_out_q == 5'd0) && (N < 32)) |-> (min_q == 0 && max_q == 0))
    else $error("empty result with nonzero extremes");

  a_no_change_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (status == smid_pkg::StNotFound || status == smid_pkg::StFull))
      |=> $stable(count_q))
    else $error("failed operation changed count");
`endif

endmodule

`default_nettype wire
